>>> design/curve_flat_run_detector_assert.svh
// Assertion macros shared by the flat-run detector modules.
// Each macro expects the including module to have clock and reset signals.
`ifndef CURVE_FLAT_RUN_DETECTOR_ASSERT_SVH
`define CURVE_FLAT_RUN_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFRD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfrd check failed");

// Consequent must hold in the cycle after the antecedent.
`define CFRD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfrd check failed");

`endif

>>> design/cfrd_pkg.sv
// Package for the curve flat-run detector: constants, codes and shared types.
// Used by every design module and interface; depends on nothing.
`timescale 1ns / 1ps

package cfrd_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int FIELD_WIDTH     = 32;
   localparam int SUM_WIDTH       = FIELD_WIDTH + 1;
   localparam int TAN_WIDTH       = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int SCALE_WIDTH     = 7;
   localparam int FLAT_SCALE      = 100;
   localparam int END_GAP         = 2048;   // 8.0 in 24.8
   localparam int MIN_LEN         = 2560;   // 10.0 in 24.8
   localparam int TAN_RESET       = 25;

   localparam logic [FIELD_WIDTH-1:0] RES_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_S_CURVE_TAN  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MULTI_MASTER = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDIT_GLYPH   = 2'd2;

   typedef enum logic [1:0] {
      DIR_START = 2'd0,
      DIR_UP    = 2'd1,
      DIR_DOWN  = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      RES_HORIZ    = 2'd0,
      RES_VERT     = 2'd1,
      RES_CONFLICT = 2'd2,
      RES_INFLECT  = 2'd3
   } result_kind_type;

   typedef struct packed {
      dir_type dir;
      dir_type first;
      logic    flat;
      logic    done;
   } axis_ctl_type;

   typedef struct packed {
      logic [TAN_WIDTH-1:0] s_curve_tan;
      logic                 multi_master;
      logic                 edit_glyph;
   } cfg_type;

   typedef struct packed {
      result_kind_type               kind;
      logic                          negate;
      logic signed [FIELD_WIDTH-1:0] seg_from;
      logic signed [FIELD_WIDTH-1:0] seg_to;
      logic signed [SUM_WIDTH-1:0]   run_sum;
   } event_type;

   typedef struct packed {
      logic      two;
      event_type ev0;
      event_type ev1;
   } entry_type;

endpackage

>>> design/cfrd_req_if.sv
// Request channel of the flat-run detector: valid/ready plus one curve item.
// Depends on cfrd_pkg for field widths.
`timescale 1ns / 1ps

interface cfrd_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    kind;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] pt_x;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] pt_y;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] end_x;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] end_y;

   modport source (output valid, kind, pt_x, pt_y, end_x, end_y, input ready);
   modport sink   (input valid, kind, pt_x, pt_y, end_x, end_y, output ready);
endinterface

>>> design/cfrd_rsp_if.sv
// Result channel of the flat-run detector: valid/ready plus one result.
// Depends on cfrd_pkg for field widths and the result kind type.
`timescale 1ns / 1ps

interface cfrd_rsp_if;
   logic                                    valid;
   logic                                    ready;
   cfrd_pkg::result_kind_type               result_kind;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] seg_from;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] seg_to;
   logic signed [cfrd_pkg::FIELD_WIDTH-1:0] location;
   logic                                    last_result;

   modport source (output valid, result_kind, seg_from, seg_to, location, last_result,
                   input ready);
   modport sink   (input valid, result_kind, seg_from, seg_to, location, last_result,
                   output ready);
endinterface

>>> design/cfrd_axis.sv
// One axis lane of the flat-run detector: direction tracking, flatness tests
// and run-end checks for a single point. Combinational; depends on cfrd_pkg.
`timescale 1ns / 1ps

module cfrd_axis #(
   parameter int COORD_WIDTH = cfrd_pkg::COORD_WIDTH_DEF
) (
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] cur_along,
   input  logic signed [COORD_WIDTH-1:0] cur_cross,
   input  logic signed [COORD_WIDTH-1:0] prev_along,
   input  logic signed [COORD_WIDTH-1:0] prev_cross,
   input  logic signed [COORD_WIDTH-1:0] end0_along,
   input  logic signed [COORD_WIDTH-1:0] end1_along,
   input  logic [cfrd_pkg::TAN_WIDTH-1:0] s_curve_tan,
   input  cfrd_pkg::axis_ctl_type        ctl,
   input  logic signed [COORD_WIDTH-1:0] start_along,
   input  logic signed [COORD_WIDTH-1:0] start_cross,
   input  logic signed [COORD_WIDTH-1:0] end_along,
   input  logic signed [COORD_WIDTH-1:0] end_cross,
   output cfrd_pkg::axis_ctl_type        ctl_nx,
   output logic signed [COORD_WIDTH-1:0] start_along_nx,
   output logic signed [COORD_WIDTH-1:0] start_cross_nx,
   output logic signed [COORD_WIDTH-1:0] end_along_nx,
   output logic signed [COORD_WIDTH-1:0] end_cross_nx,
   output logic                          hit_bad,
   output logic                          hit_run,
   output logic signed [COORD_WIDTH:0]   run_sum
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int SW = cfrd_pkg::SCALE_WIDTH;
   localparam int TW = cfrd_pkg::TAN_WIDTH;
   localparam int PW = CW + TW;

   function automatic logic signed [CW:0] sdiff(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
      return {a[CW-1], a} - {b[CW-1], b};
   endfunction

   function automatic logic [CW-1:0] adiff(input logic signed [CW-1:0] a,
                                           input logic signed [CW-1:0] b);
      logic signed [CW:0] d;
      d = sdiff(a, b);
      return d[CW] ? CW'(-d) : d[CW-1:0];
   endfunction

   logic signed [CW:0]   mv;
   logic [CW-1:0]        mv_mag;
   logic [CW-1:0]        cr_mag;
   logic [SW-1:0]        scale_c;
   logic [CW+SW-1:0]     mv_prod;
   logic [PW-1:0]        cr_prod;
   logic [PW-1:0]        mv_cmp;
   logic                 steep_lt;
   logic                 steep_gt;
   cfrd_pkg::dir_type    want;
   cfrd_pkg::axis_ctl_type ctl1;
   logic signed [CW-1:0] sa, sc, ea, ec;
   logic                 ended;
   logic                 far;
   logic                 bad;
   logic                 long_run;

   assign mv       = sdiff(cur_along, prev_along);
   assign mv_mag   = adiff(cur_along, prev_along);
   assign cr_mag   = adiff(cur_cross, prev_cross);
   assign scale_c  = SW'(cfrd_pkg::FLAT_SCALE);
   assign mv_prod  = mv_mag * scale_c;
   assign cr_prod  = cr_mag * s_curve_tan;
   assign mv_cmp   = PW'(mv_prod);
   assign steep_lt = mv_cmp < cr_prod;
   assign steep_gt = mv_cmp > cr_prod;

   always_comb begin
      ctl1     = ctl;
      sa       = start_along;
      sc       = start_cross;
      ea       = end_along;
      ec       = end_cross;
      ended    = 1'b0;
      far      = 1'b0;
      bad      = 1'b0;
      long_run = 1'b0;
      if (mv[CW]) begin
         want = cfrd_pkg::DIR_DOWN;
      end else if (mv != '0) begin
         want = cfrd_pkg::DIR_UP;
      end else begin
         want = cfrd_pkg::DIR_START;
      end

      if (want != cfrd_pkg::DIR_START && ctl.dir != want) begin
         if (ctl.dir == cfrd_pkg::DIR_START) begin
            ctl1.dir   = want;
            ctl1.first = want;
         end else begin
            if (ctl.first == want) begin
               ea = prev_along;
               ec = prev_cross;
            end else if (!ctl.flat) begin
               sa        = prev_along;
               sc        = prev_cross;
               ctl1.flat = 1'b1;
            end
            ctl1.dir = want;
         end
      end

      if (!ctl1.flat) begin
         if (steep_lt) begin
            ctl1.flat = 1'b1;
            sa        = prev_along;
            sc        = prev_cross;
         end
      end else if (ctl1.dir == ctl1.first && steep_gt) begin
         ea        = prev_along;
         ec        = prev_cross;
         ctl1.done = 1'b1;
         ended     = 1'b1;
         far = (adiff(sa, end0_along) > CW'(cfrd_pkg::END_GAP)) &&
               (adiff(end1_along, prev_along) > CW'(cfrd_pkg::END_GAP));
         bad = (ctl1.first == cfrd_pkg::DIR_UP &&
                sdiff(sa, prev_along) > $signed(DW'(cfrd_pkg::END_GAP))) ||
               (ctl1.first == cfrd_pkg::DIR_DOWN &&
                sdiff(prev_along, sa) > $signed(DW'(cfrd_pkg::END_GAP)));
         long_run = adiff(sc, prev_cross) > CW'(cfrd_pkg::MIN_LEN);
      end
   end

   assign ctl_nx         = en ? ctl1 : ctl;
   assign start_along_nx = en ? sa : start_along;
   assign start_cross_nx = en ? sc : start_cross;
   assign end_along_nx   = en ? ea : end_along;
   assign end_cross_nx   = en ? ec : end_cross;
   assign hit_bad        = en && ended && far && bad;
   assign hit_run        = en && ended && far && !bad && long_run;
   assign run_sum        = {sa[CW-1], sa} + {prev_along[CW-1], prev_along};

endmodule

>>> design/cfrd_front.sv
// Front end of the flat-run detector: accepts items, keeps curve and run state
// and classifies run ends into queue entries. Depends on cfrd_pkg, cfrd_req_if, cfrd_axis.
`timescale 1ns / 1ps

module cfrd_front #(
   parameter int COORD_WIDTH = cfrd_pkg::COORD_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   cfrd_req_if.sink            req_if,
   input  cfrd_pkg::cfg_type   cfg,
   input  logic                full,
   output logic                push,
   output cfrd_pkg::entry_type push_entry
);

   localparam int CW = COORD_WIDTH;
   localparam int FW = cfrd_pkg::FIELD_WIDTH;
   localparam int SW = cfrd_pkg::SUM_WIDTH;

   function automatic cfrd_pkg::event_type make_event(
      input logic                      is_conf,
      input logic                      mm,
      input cfrd_pkg::result_kind_type seg_kind,
      input logic                      neg_axis,
      input logic signed [CW-1:0]      from,
      input logic signed [CW-1:0]      to,
      input logic signed [CW:0]        sum
   );
      cfrd_pkg::event_type ev;
      ev.negate   = 1'b0;
      ev.seg_from = '0;
      ev.seg_to   = '0;
      ev.run_sum  = '0;
      if (is_conf) begin
         ev.kind = cfrd_pkg::RES_CONFLICT;
      end else if (mm) begin
         ev.kind    = cfrd_pkg::RES_INFLECT;
         ev.negate  = neg_axis;
         ev.run_sum = SW'(sum);
      end else begin
         ev.kind     = seg_kind;
         ev.seg_from = FW'(from);
         ev.seg_to   = FW'(to);
         ev.run_sum  = SW'(sum);
      end
      return ev;
   endfunction

   cfrd_pkg::axis_ctl_type y_ctl_ff, y_ctl_in, y_ctl_nx;
   cfrd_pkg::axis_ctl_type x_ctl_ff, x_ctl_in, x_ctl_nx;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] end0_x_ff, end0_x_in, end0_y_ff, end0_y_in;
   logic signed [CW-1:0] end1_x_ff, end1_x_in, end1_y_ff, end1_y_in;
   logic signed [CW-1:0] y_sa_ff, y_sa_in, y_sc_ff, y_sc_in;
   logic signed [CW-1:0] y_ea_ff, y_ea_in, y_ec_ff, y_ec_in;
   logic signed [CW-1:0] x_sa_ff, x_sa_in, x_sc_ff, x_sc_in;
   logic signed [CW-1:0] x_ea_ff, x_ea_in, x_ec_ff, x_ec_in;
   logic signed [CW-1:0] y_sa_nx, y_sc_nx, y_ea_nx, y_ec_nx;
   logic signed [CW-1:0] x_sa_nx, x_sc_nx, x_ea_nx, x_ec_nx;
   logic signed [CW-1:0] cur_x, cur_y, in_end_x, in_end_y;
   logic signed [CW:0]   y_sum, x_sum;
   logic                 y_hit_bad, y_hit_run, x_hit_bad, x_hit_run;
   logic                 y_en, x_en, stop, accept;
   logic                 conf_ok, emit_y, emit_x;
   cfrd_pkg::event_type  ev_y, ev_x;

   assign cur_x    = req_if.pt_x[CW-1:0];
   assign cur_y    = req_if.pt_y[CW-1:0];
   assign in_end_x = req_if.end_x[CW-1:0];
   assign in_end_y = req_if.end_y[CW-1:0];

   assign req_if.ready = !full;
   assign accept       = req_if.valid && !full;

   // y axis (horizontal runs) goes first; a bad reversal there skips x
   assign y_en = !y_ctl_ff.done;
   assign x_en = !x_ctl_ff.done && !y_hit_bad;

   cfrd_axis #(.COORD_WIDTH(CW)) u_axis_y (
      .en             (y_en),
      .cur_along      (cur_y),
      .cur_cross      (cur_x),
      .prev_along     (prev_y_ff),
      .prev_cross     (prev_x_ff),
      .end0_along     (end0_y_ff),
      .end1_along     (end1_y_ff),
      .s_curve_tan    (cfg.s_curve_tan),
      .ctl            (y_ctl_ff),
      .start_along    (y_sa_ff),
      .start_cross    (y_sc_ff),
      .end_along      (y_ea_ff),
      .end_cross      (y_ec_ff),
      .ctl_nx         (y_ctl_nx),
      .start_along_nx (y_sa_nx),
      .start_cross_nx (y_sc_nx),
      .end_along_nx   (y_ea_nx),
      .end_cross_nx   (y_ec_nx),
      .hit_bad        (y_hit_bad),
      .hit_run        (y_hit_run),
      .run_sum        (y_sum)
   );

   cfrd_axis #(.COORD_WIDTH(CW)) u_axis_x (
      .en             (x_en),
      .cur_along      (cur_x),
      .cur_cross      (cur_y),
      .prev_along     (prev_x_ff),
      .prev_cross     (prev_y_ff),
      .end0_along     (end0_x_ff),
      .end1_along     (end1_x_ff),
      .s_curve_tan    (cfg.s_curve_tan),
      .ctl            (x_ctl_ff),
      .start_along    (x_sa_ff),
      .start_cross    (x_sc_ff),
      .end_along      (x_ea_ff),
      .end_cross      (x_ec_ff),
      .ctl_nx         (x_ctl_nx),
      .start_along_nx (x_sa_nx),
      .start_cross_nx (x_sc_nx),
      .end_along_nx   (x_ea_nx),
      .end_cross_nx   (x_ec_nx),
      .hit_bad        (x_hit_bad),
      .hit_run        (x_hit_run),
      .run_sum        (x_sum)
   );

   assign stop    = y_hit_bad || x_hit_bad;
   assign conf_ok = cfg.edit_glyph && !cfg.multi_master;
   assign emit_y  = y_hit_run || (y_hit_bad && conf_ok);
   assign emit_x  = x_hit_run || (x_hit_bad && conf_ok);

   assign ev_y = make_event(y_hit_bad, cfg.multi_master, cfrd_pkg::RES_HORIZ, 1'b1,
                            y_sc_nx, y_ec_nx, y_sum);
   assign ev_x = make_event(x_hit_bad, cfg.multi_master, cfrd_pkg::RES_VERT, 1'b0,
                            x_sc_nx, x_ec_nx, x_sum);

   assign push           = accept && req_if.kind == cfrd_pkg::KIND_POINT &&
                           (emit_y || emit_x);
   assign push_entry.two = emit_y && emit_x;
   assign push_entry.ev0 = emit_y ? ev_y : ev_x;
   assign push_entry.ev1 = ev_x;

   always_comb begin
      y_ctl_in  = y_ctl_ff;
      x_ctl_in  = x_ctl_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      end0_x_in = end0_x_ff;
      end0_y_in = end0_y_ff;
      end1_x_in = end1_x_ff;
      end1_y_in = end1_y_ff;
      y_sa_in   = y_sa_ff;
      y_sc_in   = y_sc_ff;
      y_ea_in   = y_ea_ff;
      y_ec_in   = y_ec_ff;
      x_sa_in   = x_sa_ff;
      x_sc_in   = x_sc_ff;
      x_ea_in   = x_ea_ff;
      x_ec_in   = x_ec_ff;
      if (accept) begin
         if (req_if.kind == cfrd_pkg::KIND_START) begin
            // first direction and run bounds survive a new curve
            y_ctl_in.dir  = cfrd_pkg::DIR_START;
            y_ctl_in.flat = 1'b0;
            y_ctl_in.done = 1'b0;
            x_ctl_in.dir  = cfrd_pkg::DIR_START;
            x_ctl_in.flat = 1'b0;
            x_ctl_in.done = 1'b0;
            end0_x_in     = cur_x;
            end0_y_in     = cur_y;
            end1_x_in     = in_end_x;
            end1_y_in     = in_end_y;
            prev_x_in     = cur_x;
            prev_y_in     = cur_y;
         end else begin
            y_ctl_in = y_ctl_nx;
            x_ctl_in = x_ctl_nx;
            y_sa_in  = y_sa_nx;
            y_sc_in  = y_sc_nx;
            y_ea_in  = y_ea_nx;
            y_ec_in  = y_ec_nx;
            x_sa_in  = x_sa_nx;
            x_sc_in  = x_sc_nx;
            x_ea_in  = x_ea_nx;
            x_ec_in  = x_ec_nx;
            if (!stop) begin
               prev_x_in = cur_x;
               prev_y_in = cur_y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ctl_ff  <= '{dir: cfrd_pkg::DIR_START, first: cfrd_pkg::DIR_START,
                        flat: 1'b0, done: 1'b0};
         x_ctl_ff  <= '{dir: cfrd_pkg::DIR_START, first: cfrd_pkg::DIR_START,
                        flat: 1'b0, done: 1'b0};
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         end0_x_ff <= '0;
         end0_y_ff <= '0;
         end1_x_ff <= '0;
         end1_y_ff <= '0;
         y_sa_ff   <= '0;
         y_sc_ff   <= '0;
         y_ea_ff   <= '0;
         y_ec_ff   <= '0;
         x_sa_ff   <= '0;
         x_sc_ff   <= '0;
         x_ea_ff   <= '0;
         x_ec_ff   <= '0;
      end else begin
         y_ctl_ff  <= y_ctl_in;
         x_ctl_ff  <= x_ctl_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         end0_x_ff <= end0_x_in;
         end0_y_ff <= end0_y_in;
         end1_x_ff <= end1_x_in;
         end1_y_ff <= end1_y_in;
         y_sa_ff   <= y_sa_in;
         y_sc_ff   <= y_sc_in;
         y_ea_ff   <= y_ea_in;
         y_ec_ff   <= y_ec_in;
         x_sa_ff   <= x_sa_in;
         x_sc_ff   <= x_sc_in;
         x_ea_ff   <= x_ea_in;
         x_ec_ff   <= x_ec_in;
      end
   end

endmodule

>>> design/cfrd_queue.sv
// Short queue of classified entries between the front and back ends.
// Depends on cfrd_pkg for the entry type and the assertion macro header.
`timescale 1ns / 1ps
`include "curve_flat_run_detector_assert.svh"

module cfrd_queue #(
   parameter int DEPTH = cfrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cfrd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output cfrd_pkg::entry_type head
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   cfrd_pkg::entry_type mem_ff [DEPTH];
   logic [PTRW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]     count_ff, count_in;

   assign full  = count_ff == CNTW'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CFRD_ASSERT_NOW(a_no_push_full, push, !full)
   `CFRD_ASSERT_NOW(a_no_pop_empty, pop, !empty)
   `CFRD_ASSERT_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

>>> design/cfrd_back.sv
// Back end of the flat-run detector: unpacks queue entries into results,
// finishes midpoint and inflection values, drives the result register.
// Depends on cfrd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "curve_flat_run_detector_assert.svh"

module cfrd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  cfrd_pkg::entry_type head,
   output logic                pop,
   cfrd_rsp_if.source          rsp_if
);

   localparam int FW = cfrd_pkg::FIELD_WIDTH;
   localparam int SW = cfrd_pkg::SUM_WIDTH;

   logic                      valid_ff, valid_in;
   logic                      sel_ff, sel_in;
   cfrd_pkg::result_kind_type kind_ff;
   logic signed [FW-1:0]      from_ff, to_ff, loc_ff;
   logic                      last_ff;
   cfrd_pkg::event_type       cur;
   logic                      is_last;
   logic                      load;
   logic [SW-1:0]             adj;
   logic signed [FW-1:0]      half;
   logic signed [SW-1:0]      neg;
   logic signed [FW-1:0]      loc;

   assign cur     = sel_ff ? head.ev1 : head.ev0;
   assign is_last = sel_ff || !head.two;
   assign load    = !empty && (!valid_ff || rsp_if.ready);
   assign pop     = load && is_last;

   // midpoint truncated toward zero
   assign adj  = cur.run_sum + SW'(cur.run_sum[SW-1]);
   assign half = adj[SW-1:1];
   assign neg  = -{half[FW-1], half};
   assign loc  = !cur.negate ? half :
                 ($signed(neg) > $signed({1'b0, cfrd_pkg::RES_MAX})) ?
                    $signed(cfrd_pkg::RES_MAX) : neg[FW-1:0];

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = !is_last;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= cur.kind;
         from_ff <= cur.seg_from;
         to_ff   <= cur.seg_to;
         loc_ff  <= loc;
         last_ff <= is_last;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.result_kind = kind_ff;
   assign rsp_if.seg_from    = from_ff;
   assign rsp_if.seg_to      = to_ff;
   assign rsp_if.location    = loc_ff;
   assign rsp_if.last_result = last_ff;

   `CFRD_ASSERT_NOW(a_second_has_entry, sel_ff, !empty && head.two)

endmodule

>>> design/curve_flat_run_detector.sv
// Flat-run detector for the points of one flattened cubic curve.
// Send a start item (kind 0) with the curve's first and last point, then one
// point item (kind 1) per flattened point on the req_ channel; results come
// out on the rsp_ channel, up to two per point, the last one of each point
// flagged by last_result. Items that cause no result produce nothing.
// Throughput: one item per cycle at the request side while the queue is not
// full; the result side moves one result per cycle while the receiver is
// ready. The front end holds all curve state and decides each point when it
// is accepted; its results pass through the queue into the result register.
// A queue of QUEUE_DEPTH entries sits between the front end and the result
// register; ready drops only while the queue is full, so a stalled receiver
// backs up into the request side once QUEUE_DEPTH result groups wait in it.
// Reset (synchronous, active high) clears all curve and run state, empties
// the queue and loads s_curve_tan 25, multi_master 0, edit_glyph 0.
// csr_ writes take effect at the clock edge; write only while idle.
// Depends on cfrd_pkg, cfrd_req_if, cfrd_rsp_if, cfrd_front, cfrd_queue,
// cfrd_back.
`timescale 1ns / 1ps

module curve_flat_run_detector #(
   parameter int COORD_WIDTH = cfrd_pkg::COORD_WIDTH_DEF,
   parameter int QUEUE_DEPTH = cfrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   cfrd_req_if.sink                               req_if,
   cfrd_rsp_if.source                             rsp_if,
   input  logic                                   csr_we,
   input  logic [cfrd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cfrd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int TW = cfrd_pkg::TAN_WIDTH;

   cfrd_pkg::cfg_type   cfg_ff, cfg_in;
   logic                push, pop, full, empty;
   cfrd_pkg::entry_type push_entry, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cfrd_pkg::REG_S_CURVE_TAN:  cfg_in.s_curve_tan  = csr_wdata[TW-1:0];
            cfrd_pkg::REG_MULTI_MASTER: cfg_in.multi_master = csr_wdata[0];
            cfrd_pkg::REG_EDIT_GLYPH:   cfg_in.edit_glyph   = csr_wdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{s_curve_tan: TW'(cfrd_pkg::TAN_RESET), multi_master: 1'b0,
                     edit_glyph: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfrd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .full       (full),
      .push       (push),
      .push_entry (push_entry)
   );

   cfrd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   cfrd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

>>> sim/tb.sv
// Self-checking testbench for curve_flat_run_detector: shaped and random curves
// on req_ch, results checked in order against a cycle-free model of the block.
// Depends on cfrd_pkg, cfrd_req_if, cfrd_rsp_if and the design top level.
`timescale 1ns / 1ps

module tb;

   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 155;
   localparam int MAX_REPORTS    = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int TAIL_CYCLES    = 10;
   localparam int FW             = cfrd_pkg::FIELD_WIDTH;
   localparam int TW             = cfrd_pkg::TAN_WIDTH;

   typedef struct packed {
      logic                 kind;
      logic signed [FW-1:0] pt_x;
      logic signed [FW-1:0] pt_y;
      logic signed [FW-1:0] end_x;
      logic signed [FW-1:0] end_y;
   } curve_req_type;

   typedef struct packed {
      cfrd_pkg::result_kind_type kind;
      logic signed [FW-1:0]      seg_from;
      logic signed [FW-1:0]      seg_to;
      logic signed [FW-1:0]      location;
      logic                      last;
   } run_result_type;

   typedef enum int {SHAPE_PLAIN, SHAPE_REVERSAL, SHAPE_MIXED} curve_shape_type;
   typedef enum int {PH_STEEP, PH_FLAT, PH_BACK, PH_NOISE} curve_phase_type;

   class flat_run_checker;
      logic [TW-1:0]        tan;
      bit                   mm;
      bit                   eg;
      cfrd_pkg::dir_type    cur_dir[2];
      cfrd_pkg::dir_type    first_dir[2];
      bit                   flat[2];
      bit                   done[2];
      longint               prev[2];
      longint               ends[4];
      longint               bounds[2][4];
      run_result_type       group[$];
      run_result_type       awaited_runs[$];
      int                   errors;

      function new();
         tan = TW'(cfrd_pkg::TAN_RESET);
         mm = 1'b0;
         eg = 1'b0;
         errors = 0;
         for (int k = 0; k < 2; k++) begin
            cur_dir[k] = cfrd_pkg::DIR_START;
            first_dir[k] = cfrd_pkg::DIR_START;
            flat[k] = 1'b0;
            done[k] = 1'b0;
            prev[k] = 0;
            for (int j = 0; j < 4; j++) bounds[k][j] = 0;
         end
         for (int j = 0; j < 4; j++) ends[j] = 0;
      endfunction

      function void write_reg(logic [cfrd_pkg::CSR_INDEX_WIDTH-1:0] idx, int unsigned val);
         case (idx)
            cfrd_pkg::REG_S_CURVE_TAN:  tan = val[TW-1:0];
            cfrd_pkg::REG_MULTI_MASTER: mm = val[0];
            cfrd_pkg::REG_EDIT_GLYPH:   eg = val[0];
            default: ;
         endcase
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function void add_result(cfrd_pkg::result_kind_type kind, longint from, longint to,
                               longint loc);
         run_result_type r;
         r.kind = kind;
         r.seg_from = from[FW-1:0];
         r.seg_to = to[FW-1:0];
         r.location = loc[FW-1:0];
         r.last = 1'b0;
         group.push_back(r);
      endfunction

      // k = 1: y axis, horizontal runs; k = 0: x axis, vertical runs
      function bit track_axis(int k, longint cur[2]);
         int                c;
         longint            mv, cr, tan_l, loc, v;
         cfrd_pkg::dir_type want;
         c = 1 - k;
         mv = cur[k] - prev[k];
         cr = cur[c] - prev[c];
         tan_l = longint'(tan);
         want = (mv > 0) ? cfrd_pkg::DIR_UP :
                ((mv < 0) ? cfrd_pkg::DIR_DOWN : cfrd_pkg::DIR_START);

         if (want != cfrd_pkg::DIR_START && cur_dir[k] != want) begin
            if (cur_dir[k] == cfrd_pkg::DIR_START) begin
               cur_dir[k] = want;
               first_dir[k] = want;
            end else begin
               if (first_dir[k] == want) begin
                  bounds[k][2] = prev[0];
                  bounds[k][3] = prev[1];
               end else if (!flat[k]) begin
                  bounds[k][0] = prev[0];
                  bounds[k][1] = prev[1];
                  flat[k] = 1'b1;
               end
               cur_dir[k] = want;
            end
         end

         if (!flat[k]) begin
            if (mag(mv) * cfrd_pkg::FLAT_SCALE < mag(cr) * tan_l) begin
               flat[k] = 1'b1;
               bounds[k][0] = prev[0];
               bounds[k][1] = prev[1];
            end
            return 1'b0;
         end
         if (cur_dir[k] != first_dir[k]) return 1'b0;
         if (!(mag(mv) * cfrd_pkg::FLAT_SCALE > mag(cr) * tan_l)) return 1'b0;
         bounds[k][2] = prev[0];
         bounds[k][3] = prev[1];
         done[k] = 1'b1;

         if (mag(bounds[k][k] - ends[k]) > cfrd_pkg::END_GAP &&
             mag(ends[2+k] - bounds[k][2+k]) > cfrd_pkg::END_GAP) begin
            if ((first_dir[k] == cfrd_pkg::DIR_UP &&
                 bounds[k][k] - bounds[k][2+k] > cfrd_pkg::END_GAP) ||
                (first_dir[k] == cfrd_pkg::DIR_DOWN &&
                 bounds[k][2+k] - bounds[k][k] > cfrd_pkg::END_GAP)) begin
               if (eg && !mm) add_result(cfrd_pkg::RES_CONFLICT, 0, 0, 0);
               return 1'b1;
            end
            if (mag(bounds[k][c] - bounds[k][2+c]) > cfrd_pkg::MIN_LEN) begin
               loc = (bounds[k][k] + bounds[k][2+k]) / 2;
               if (!mm) begin
                  add_result(k == 1 ? cfrd_pkg::RES_HORIZ : cfrd_pkg::RES_VERT,
                             bounds[k][c], bounds[k][2+c], loc);
               end else begin
                  v = loc;
                  if (k == 1) begin
                     v = -loc;
                     if (v > longint'(cfrd_pkg::RES_MAX)) v = longint'(cfrd_pkg::RES_MAX);
                  end
                  add_result(cfrd_pkg::RES_INFLECT, 0, 0, v);
               end
            end
         end
         return 1'b0;
      endfunction

      function void take_point(curve_req_type r);
         longint cur[2];
         bit     stop;
         group.delete();
         cur[0] = longint'(r.pt_x);
         cur[1] = longint'(r.pt_y);
         if (r.kind == cfrd_pkg::KIND_START) begin
            cur_dir[0] = cfrd_pkg::DIR_START;
            cur_dir[1] = cfrd_pkg::DIR_START;
            flat = '{1'b0, 1'b0};
            done = '{1'b0, 1'b0};
            ends[0] = cur[0];
            ends[1] = cur[1];
            ends[2] = longint'(r.end_x);
            ends[3] = longint'(r.end_y);
            prev = cur;
            return;
         end
         stop = 1'b0;
         if (!done[1]) stop = track_axis(1, cur);
         if (!stop && !done[0]) stop = track_axis(0, cur);
         if (!stop) prev = cur;
         if (group.size() > 0) group[group.size()-1].last = 1'b1;
         foreach (group[i]) awaited_runs.push_back(group[i]);
      endfunction

      function void complain(string what, run_result_type exp_r, run_result_type got,
                             bit show_exp);
         errors++;
         if (errors <= MAX_REPORTS) begin
            if (show_exp)
               $display("%s: expected kind %0d from %0d to %0d loc %0d last %0d", what,
                        exp_r.kind, exp_r.seg_from, exp_r.seg_to, exp_r.location, exp_r.last);
            if (what != "missing result")
               $display("%s: actual   kind %0d from %0d to %0d loc %0d last %0d", what,
                        got.kind, got.seg_from, got.seg_to, got.location, got.last);
         end
      endfunction

      function void check_segment(run_result_type got);
         run_result_type exp_r;
         if (awaited_runs.size() == 0) begin
            complain("unexpected result", got, got, 1'b0);
            return;
         end
         exp_r = awaited_runs.pop_front();
         if (got.kind !== exp_r.kind || got.seg_from !== exp_r.seg_from ||
             got.seg_to !== exp_r.seg_to || got.location !== exp_r.location ||
             got.last !== exp_r.last)
            complain("result mismatch", exp_r, got, 1'b1);
      endfunction

      function void flush_missing();
         run_result_type exp_r;
         while (awaited_runs.size() > 0) begin
            exp_r = awaited_runs.pop_front();
            complain("missing result", exp_r, exp_r, 1'b1);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [cfrd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [cfrd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   cfrd_req_if req_ch();
   cfrd_rsp_if rsp_ch();

   flat_run_checker sb;
   int  items_sent;
   int  idle_cycles;
   bit  req_calm;

   curve_flat_run_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint rand_mag(int lo, int hi);
      return longint'($urandom_range(hi, lo));
   endfunction

   function automatic longint rand_signed(int lim);
      return rand_mag(0, 2 * lim) - longint'(lim);
   endfunction

   task automatic send_req(input curve_req_type it);
      int gap;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.kind = it.kind;
      req_ch.pt_x = it.pt_x;
      req_ch.pt_y = it.pt_y;
      req_ch.end_x = it.end_x;
      req_ch.end_y = it.end_y;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_point(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_fields(input logic kind, input logic [FW-1:0] x, y, ex, ey);
      curve_req_type it;
      it.kind = kind;
      it.pt_x = x;
      it.pt_y = y;
      it.end_x = ex;
      it.end_y = ey;
      send_req(it);
   endtask

   // start request, then points: steep legs along one axis with flat stretches, reversals or noise steps
   task automatic send_curve(input bit vert, input curve_shape_type shape, input bit brief);
      curve_phase_type        plan[$];
      longint                 pa[$], pc[$];
      longint                 along, across, step_a, step_c, dir_a, dir_c;
      logic [FW-1:0]          xv, yv, ex, ey;
      int                     reps;
      plan.push_back(PH_STEEP);
      case (shape)
         SHAPE_PLAIN: begin
            plan.push_back(PH_FLAT);
            plan.push_back(PH_STEEP);
         end
         SHAPE_REVERSAL: begin
            plan.push_back(PH_FLAT);
            plan.push_back(PH_BACK);
            plan.push_back(PH_STEEP);
         end
         default: begin
            repeat ($urandom_range(1, 5))
               plan.push_back(curve_phase_type'($urandom_range(0, 3)));
         end
      endcase
      dir_a = ($urandom_range(0, 1) == 1) ? 1 : -1;
      dir_c = ($urandom_range(0, 1) == 1) ? 1 : -1;
      along = rand_signed(1 << 27);
      across = rand_signed(1 << 27);
      pa.push_back(along);
      pc.push_back(across);
      foreach (plan[i]) begin
         reps = brief ? 1 : $urandom_range(1, 3);
         repeat (reps) begin
            case (plan[i])
               PH_STEEP: begin
                  step_a = dir_a * rand_mag(2200, 6000);
                  step_c = rand_signed(150);
               end
               PH_FLAT: begin
                  step_a = rand_signed(20);
                  step_c = dir_c * rand_mag(1500, 4000);
                  if ($urandom_range(0, 7) == 0) step_c = -step_c;
               end
               PH_BACK: begin
                  step_a = -dir_a * rand_mag(2200, 6000);
                  step_c = rand_signed(150);
               end
               default: begin
                  step_a = rand_signed(8000);
                  step_c = rand_signed(8000);
               end
            endcase
            along += step_a;
            across += step_c;
            pa.push_back(along);
            pc.push_back(across);
         end
      end
      ex = FW'(vert ? pa[pa.size()-1] : pc[pc.size()-1]);
      ey = FW'(vert ? pc[pc.size()-1] : pa[pa.size()-1]);
      if ($urandom_range(0, 5) == 0) begin
         ex = $urandom;
         ey = $urandom;
      end
      for (int i = 0; i < pa.size(); i++) begin
         xv = FW'(vert ? pa[i] : pc[i]);
         yv = FW'(vert ? pc[i] : pa[i]);
         if (i == 0) send_fields(cfrd_pkg::KIND_START, xv, yv, ex, ey);
         else send_fields(cfrd_pkg::KIND_POINT, xv, yv, $urandom, $urandom);
      end
   endtask

   task automatic wait_drain();
      while (sb.awaited_runs.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [cfrd_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input int unsigned val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val[cfrd_pkg::CSR_DATA_WIDTH-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, val);
   endtask

   // receiver: random stalls, with calm stretches that start no new stalls
   initial begin
      int stall;
      int stretch;
      bit calm;
      rsp_ch.ready = 1'b0;
      stall = 0;
      stretch = 0;
      calm = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(20, 200);
         end else begin
            stretch--;
         end
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            stall--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (!calm) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      run_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind = rsp_ch.result_kind;
         got.seg_from = rsp_ch.seg_from;
         got.seg_to = rsp_ch.seg_to;
         got.location = rsp_ch.location;
         got.last = rsp_ch.last_result;
         sb.check_segment(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL curve_flat_run_detector");
         $finish;
      end
   end

   initial begin
      int unsigned tan_plan[PHASE_COUNT];
      bit          mm_plan[PHASE_COUNT];
      bit          eg_plan[PHASE_COUNT];
      int          phase_start;
      int          r;
      sb = new();
      tan_plan = '{25, 25, 1023, 0, 0, 100};
      mm_plan = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      eg_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      items_sent = 0;
      req_calm = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = cfrd_pkg::REG_S_CURVE_TAN;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = cfrd_pkg::KIND_START;
      req_ch.pt_x = '0;
      req_ch.pt_y = '0;
      req_ch.end_x = '0;
      req_ch.end_y = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // points before any start, extreme coordinates, one plain and one reversal curve per axis
      send_fields(cfrd_pkg::KIND_POINT, 32'h7fffffff, 32'h80000000, 32'h00000000,
                  32'hffffffff);
      send_fields(cfrd_pkg::KIND_POINT, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                  32'h00000000);
      send_fields(cfrd_pkg::KIND_START, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000);
      send_fields(cfrd_pkg::KIND_POINT, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  32'h7fffffff);
      send_curve(1'b0, SHAPE_PLAIN, 1'b1);
      send_curve(1'b1, SHAPE_PLAIN, 1'b1);
      send_curve(1'b0, SHAPE_REVERSAL, 1'b1);
      send_curve(1'b1, SHAPE_REVERSAL, 1'b1);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            req_ch.valid = 1'b0;
            wait_drain();
            repeat (DRAIN_CYCLES) @(negedge clock);
            write_csr(cfrd_pkg::REG_S_CURVE_TAN,
                      (p == 4) ? $urandom_range(1, 1022) : tan_plan[p]);
            write_csr(cfrd_pkg::REG_MULTI_MASTER, mm_plan[p]);
            write_csr(cfrd_pkg::REG_EDIT_GLYPH, eg_plan[p]);
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            req_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
               send_curve(bit'($urandom_range(0, 1)), SHAPE_PLAIN, 1'b0);
            else if (r < 55)
               send_curve(bit'($urandom_range(0, 1)), SHAPE_REVERSAL, 1'b0);
            else if (r < 80)
               send_curve(bit'($urandom_range(0, 1)), SHAPE_MIXED, 1'b0);
            else
               repeat ($urandom_range(1, 4))
                  send_fields(logic'($urandom_range(0, 1)), $urandom, $urandom,
                              $urandom, $urandom);
            if ($urandom_range(0, 39) == 0) begin
               req_ch.valid = 1'b0;
               wait_drain();
            end
         end
      end

      req_ch.valid = 1'b0;
      wait_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      sb.flush_missing();
      if (sb.errors == 0)
         $display("PASS curve_flat_run_detector");
      else
         $display("FAIL curve_flat_run_detector");
      $finish;
   end

endmodule

>>> curve_flat_run_detector.f
+incdir+design
design/cfrd_pkg.sv
design/cfrd_req_if.sv
design/cfrd_rsp_if.sv
design/cfrd_axis.sv
design/cfrd_front.sv
design/cfrd_queue.sv
design/cfrd_back.sv
design/curve_flat_run_detector.sv
sim/tb.sv
